FILE: rtl/aelm_pkg.sv
// shared types, constants and log table for the audio log energy meter
`timescale 1ns / 1ps

package aelm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_GROUP_LENGTH = 2'd0;
	localparam logic [1:0] REG_NOISE_FLOOR  = 2'd1;
	localparam logic [1:0] REG_FLOOR_GAIN   = 2'd2;

	// register reset values
	localparam logic [10:0] GROUP_LENGTH_RST = 11'd40;
	localparam logic [15:0] NOISE_FLOOR_RST  = 16'd13107;
	localparam logic [15:0] FLOOR_GAIN_RST   = 16'd20480;

	// width of the sum and number of normalizer steps
	localparam int SUM_W       = 41;
	localparam int NORM_STEPS  = 6;

	// floor(256*d/31) by reciprocal: q0 = (d * DIV_RECIP) >> DIV_SHIFT, then one correction
	localparam logic [22:0] DIV_RECIP  = 23'd4329604;
	localparam int          DIV_SHIFT  = 19;
	localparam logic [22:0] LOG_DIVISOR = 23'd31;

	typedef logic [7:0] log_table_t [256];

	// round(256*log2(1+i/256)) by repeated squaring, evaluated at elaboration
	function automatic log_table_t build_log_table();
		log_table_t  t;
		logic [63:0] x;
		logic [20:0] bits;
		int          i;
		int          k;
		for (i = 0; i < 256; i++) begin
			x = 64'(256 + i) << 23;
			bits = '0;
			for (k = 0; k < 20; k++) begin
				x = (x * x) >> 31;
				bits = bits << 1;
				if (x >= 64'h1_0000_0000) begin
					bits[0] = 1'b1;
					x = x >> 1;
				end
			end
			t[i] = 8'((bits + 21'd2048) >> 12);
		end
		return t;
	endfunction

	localparam log_table_t LOG_TABLE = build_log_table();

	// controller to datapath commands
	typedef struct packed {
		logic       accept;
		logic       acc;
		logic       acc_last;
		logic       norm_step;
		logic [2:0] step;
		logic       logd;
		logic       div;
		logic       corr;
		logic       gain_load;
	} aelm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last;
	} aelm_sts_t;

endpackage

FILE: rtl/audio_log_energy_meter.sv
// audio log energy meter top level: configuration port, controller and datapath
// a word that closes a group gives its level after its square is added and the close stages run
// throughput: one word a cycle inside a group; input stalls at each group close while the
//   closing square is added and the close runs: the normalizer (6 steps), the log, reciprocal
//   divide, correction and gain stages
// a finished level waits in the output register; a close that finds it unread waits for it
// reset: asynchronous, clears the sum, count, ring slot and controller, restores register defaults
`timescale 1ns / 1ps

module audio_log_energy_meter import aelm_pkg::*; #(
	parameter int ENERGY_RING_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] energy_level,
	output logic [8:0]  slot_index
);

	aelm_cmd_t cmd;
	aelm_sts_t sts;

	// registers are always writable
	assign cfg_ready = 1'b1;

	aelm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aelm_dp #(
		.ENERGY_RING_DEPTH (ENERGY_RING_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.cmd          (cmd),
		.sts          (sts),
		.energy_level (energy_level),
		.slot_index   (slot_index)
	);

endmodule

FILE: rtl/aelm_dp.sv
// datapath: square accumulator, log normalizer, scaling and output registers
`timescale 1ns / 1ps

module aelm_dp import aelm_pkg::*; #(
	parameter int ENERGY_RING_DEPTH = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [15:0] sample,
	input  aelm_cmd_t   cmd,
	output aelm_sts_t   sts,
	output logic [15:0] energy_level,
	output logic [8:0]  slot_index
);

	localparam int SW = (ENERGY_RING_DEPTH > 1) ? $clog2(ENERGY_RING_DEPTH) : 1;
	localparam logic [SW-1:0] RING_LAST = SW'(ENERGY_RING_DEPTH - 1);

	logic [10:0]      group_length_q;
	logic [15:0]      noise_floor_q;
	logic [15:0]      floor_gain_q;
	logic [SUM_W-1:0] sum_q;
	logic [10:0]      count_q;
	logic [SW-1:0]    ring_q;
	logic [16:0]      mag_s1;
	logic [SUM_W-1:0] norm_q;
	logic [5:0]       lz_q;
	logic             zero_q;
	logic [13:0]      d_q;
	logic [16:0]      q0_q;
	logic [16:0]      b_q;
	logic [15:0]      level_q;
	logic [8:0]       slot_q;

	logic [10:0]      glen_eff;
	logic [10:0]      cnt_inc;
	logic [16:0]      sx;
	logic [16:0]      mag;
	logic [33:0]      sq;
	logic [SUM_W-1:0] sum_next;
	logic [5:0]       shamt;
	logic             top_zero;
	logic [3:0]       pg;
	logic [10:0]      gx;
	logic [13:0]      ls;
	logic [13:0]      lg;
	logic [36:0]      dprod;
	logic [22:0]      rem;
	logic [16:0]      a_val;
	logic [32:0]      gprod;
	logic [18:0]      gscaled;
	logic [SW+8:0]    ring_ext;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_length_q <= GROUP_LENGTH_RST;
			noise_floor_q <= NOISE_FLOOR_RST;
			floor_gain_q <= FLOOR_GAIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GROUP_LENGTH: group_length_q <= cfg_data[10:0];
				REG_NOISE_FLOOR:  noise_floor_q <= cfg_data;
				REG_FLOOR_GAIN:   floor_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// group count and sample magnitude
	assign glen_eff = (group_length_q == '0) ? 11'd1 : group_length_q;
	assign cnt_inc = count_q + 11'd1;
	assign sts.last = (cnt_inc >= glen_eff);
	assign sx = {sample[15], sample};
	assign mag = sx[16] ? (17'd0 - sx) : sx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.accept) begin
			count_q <= sts.last ? 11'd0 : cnt_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mag_s1 <= mag;
		end
	end

	// square and accumulate; the closing word moves the sum to the normalizer
	assign sq = mag_s1 * mag_s1;
	assign sum_next = sum_q + SUM_W'(sq);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= cmd.acc_last ? '0 : sum_next;
		end
	end

	// leading zero search, one binary step a cycle: 32, 16, 8, 4, 2, 1
	assign shamt = 6'(6'd32 >> cmd.step);
	assign top_zero = ((norm_q >> (6'd41 - shamt)) == '0);

	always_ff @(posedge clk) begin
		if (cmd.acc && cmd.acc_last) begin
			norm_q <= sum_next;
			lz_q <= '0;
			zero_q <= (sum_next == '0);
		end else if (cmd.norm_step && top_zero) begin
			norm_q <= norm_q << shamt;
			lz_q <= lz_q + shamt;
		end
	end

	// priority encoder on the group length
	always_comb begin
		pg = '0;
		for (int i = 0; i < 11; i++) begin
			if (glen_eff[i]) begin
				pg = 4'(i);
			end
		end
	end

	assign gx = glen_eff << (4'd10 - pg);
	assign ls = {6'(6'd40 - lz_q), 8'd0} + 14'(LOG_TABLE[norm_q[39:32]]);
	assign lg = {2'd0, pg, 8'd0} + 14'(LOG_TABLE[gx[9:2]]);

	// log difference, clamped at zero
	always_ff @(posedge clk) begin
		if (cmd.logd) begin
			d_q <= (zero_q || (ls <= lg)) ? 14'd0 : (ls - lg);
		end
	end

	// divide by 31: reciprocal estimate
	assign dprod = d_q * DIV_RECIP;

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			q0_q <= dprod[DIV_SHIFT +: 17];
		end
	end

	// estimate correction, then noise floor subtraction
	assign rem = {1'b0, d_q, 8'd0} - (({6'd0, q0_q} << 5) - {6'd0, q0_q});
	assign a_val = (rem >= LOG_DIVISOR) ? (q0_q + 17'd1) : q0_q;

	always_ff @(posedge clk) begin
		if (cmd.corr) begin
			b_q <= (a_val > {1'b0, noise_floor_q}) ? (a_val - {1'b0, noise_floor_q}) : 17'd0;
		end
	end

	// gain and saturation into the output register
	assign gprod = b_q * floor_gain_q;
	assign gscaled = gprod[32:14];
	assign ring_ext = (SW + 9)'(ring_q);

	always_ff @(posedge clk) begin
		if (cmd.gain_load) begin
			level_q <= (gscaled > 19'd65535) ? 16'hFFFF : gscaled[15:0];
			slot_q <= ring_ext[8:0];
		end
	end

	// ring slot advances with every level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q <= '0;
		end else if (cmd.gain_load) begin
			ring_q <= (ring_q == RING_LAST) ? '0 : (ring_q + SW'(1));
		end
	end

	assign energy_level = level_q;
	assign slot_index = slot_q;

endmodule

FILE: rtl/aelm_ctrl.sv
// controller: sequences accumulation, normalization, scaling and output handoff
`timescale 1ns / 1ps

module aelm_ctrl import aelm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  aelm_sts_t sts,
	output aelm_cmd_t cmd
);

	localparam logic [2:0] ST_RUN  = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_LOGD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_CORR = 3'd4;
	localparam logic [2:0] ST_GAIN = 3'd5;

	localparam logic [2:0] LAST_STEP = 3'(NORM_STEPS - 1);

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [2:0] step_q;
	logic       pend_q;
	logic       last_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_RUN) && !(pend_q && last_q);

	// command decode and next state
	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				cmd.accept = in_valid && in_ready;
				cmd.acc = pend_q;
				cmd.acc_last = pend_q && last_q;
				if (pend_q && last_q) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				cmd.norm_step = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_LOGD;
				end
			end
			ST_LOGD: begin
				cmd.logd = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_CORR;
			end
			ST_CORR: begin
				cmd.corr = 1'b1;
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain_load = out_free;
				if (out_free) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	// state, pending square and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			step_q <= '0;
			pend_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_NORM) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
			if (state_q == ST_RUN) begin
				pend_q <= cmd.accept;
				if (cmd.accept) begin
					last_q <= sts.last;
				end
			end
		end
	end

	// output word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.gain_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a closing word sets the pending square, whose addition moves the controller to the normalizer
	a_close_to_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.last) |=> ##1 (state_q == ST_NORM))
		else $error("closing word did not start normalization");

	// a new level never overwrites a word that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gain_load |-> (!out_valid_q || out_ready))
		else $error("output word overwritten");

	// normalizer step stays within its six steps
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NORM) |-> (step_q <= LAST_STEP))
		else $error("normalizer step out of range");

	// no word taken while the closing square is still pending
	a_hold_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && last_q && (state_q == ST_RUN)) |-> !cmd.accept)
		else $error("word accepted during group close");

endmodule

FILE: tb/sv/audio_log_energy_meter_test.sv
// self-checking testbench for the audio log energy meter
`timescale 1ns / 1ps

module audio_log_energy_meter_test;
	import aelm_pkg::*;

	localparam int          ENERGY_RING_DEPTH = 512;
	localparam int unsigned RANDOM_ITEMS      = 1050;
	localparam int          SETTLE_CYCLES     = 24;
	// no register behind this index, a write must change nothing
	localparam logic [1:0]  REG_UNUSED        = 2'd3;

	typedef enum int unsigned {
		MIX_FULL,
		MIX_QUIET,
		MIX_EDGE,
		MIX_SILENT,
		MIX_LOUD,
		MIX_ANY
	} sample_mix_t;

	typedef struct packed {
		logic [15:0] energy;
		logic [8:0]  slot;
	} level_word_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index    = '0;
	logic [15:0] cfg_data     = '0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [15:0] sample       = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [15:0] energy_level;
	logic [8:0]  slot_index;

	// words waiting to be sent and levels waiting to arrive
	logic [15:0] pending_samples [$];
	level_word_t expected_levels [$];

	// register mirror
	logic [10:0] cur_glen  = GROUP_LENGTH_RST;
	logic [15:0] cur_floor = NOISE_FLOOR_RST;
	logic [15:0] cur_gain  = FLOOR_GAIN_RST;

	// accumulator mirror
	logic [40:0] acc_sum   = '0;
	logic [10:0] acc_count = '0;
	int unsigned acc_slot  = 0;

	logic [7:0]  frac_log [256];

	logic        in_taken   = 1'b0;
	logic        out_taken  = 1'b0;
	int unsigned feed_gap   = 0;
	bit          feed_calm  = 1'b0;
	int unsigned drain_gap  = 0;
	bit          drain_calm = 1'b0;

	int unsigned fail_count      = 0;
	int unsigned levels_checked  = 0;
	int unsigned samples_taken   = 0;
	int unsigned reg_writes      = 0;

	audio_log_energy_meter #(
		.ENERGY_RING_DEPTH(ENERGY_RING_DEPTH)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.energy_level(energy_level),
		.slot_index  (slot_index)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// fractional part of log2(1 + i/256) in 1/256 steps, one result bit per squaring
	function automatic logic [7:0] frac_log_of(int unsigned i);
		logic [63:0] x;
		logic [20:0] frac;
		x = 64'(256 + i) << 23;
		frac = '0;
		for (int k = 0; k < 20; k++) begin
			x = (x * x) >> 31;
			frac = {frac[19:0], 1'b0};
			if (x[63:32] != 0) begin
				frac[0] = 1'b1;
				x = x >> 1;
			end
		end
		return 8'((frac + 21'd2048) >> 12);
	endfunction

	// q6.8 log2 of a nonzero value: leading one position plus table lookup
	function automatic int unsigned log2_q8(logic [40:0] v);
		int unsigned lead;
		logic [40:0] mant;
		lead = 0;
		for (int b = 0; b < 41; b++)
			if (v[b])
				lead = b;
		if (lead >= 8)
			mant = v >> (lead - 8);
		else
			mant = v << (8 - lead);
		return lead * 256 + frac_log[mant[7:0]];
	endfunction

	// level of one closed group under the current registers
	function automatic logic [15:0] level_of_group(logic [40:0] sum, int unsigned glen);
		int unsigned      ls;
		int unsigned      lg;
		int unsigned      d;
		int unsigned      a;
		int unsigned      b;
		longint unsigned  prod;
		if (sum == 0)
			return 16'd0;
		ls = log2_q8(sum);
		lg = log2_q8(41'(glen));
		d = (ls > lg) ? ls - lg : 0;
		a = (d * 256) / 31;
		b = (a > cur_floor) ? a - cur_floor : 0;
		prod = (longint'(b) * cur_gain) >> 14;
		return (prod > 65535) ? 16'hFFFF : 16'(prod);
	endfunction

	// add one accepted word to the mirror, queue a level when the group closes
	task automatic absorb_sample(input logic [15:0] s);
		int unsigned mag;
		int unsigned glen_eff;
		level_word_t lw;
		mag = s[15] ? 32'h10000 - s : s;
		glen_eff = (cur_glen == 0) ? 1 : cur_glen;
		acc_sum = acc_sum + 41'(mag * mag);
		acc_count = acc_count + 11'd1;
		if (acc_count >= glen_eff) begin
			lw.energy = level_of_group(acc_sum, glen_eff);
			lw.slot = acc_slot[8:0];
			expected_levels.push_back(lw);
			acc_slot = (acc_slot + 1) % ENERGY_RING_DEPTH;
			acc_sum = '0;
			acc_count = '0;
		end
	endtask

	function automatic logic [15:0] pick_sample(sample_mix_t mix);
		sample_mix_t m;
		m = (mix == MIX_ANY) ? sample_mix_t'($urandom_range(0, 3)) : mix;
		case (m)
			MIX_QUIET:  return 16'($urandom_range(0, 16)) - 16'd8;
			MIX_SILENT: return 16'h0000;
			MIX_LOUD:   return 16'h8000;
			MIX_EDGE: begin
				case ($urandom_range(0, 5))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'h0000;
					3:       return 16'hFFFF;
					4:       return 16'h0001;
					default: return 16'h8001;
				endcase
			end
			default:    return 16'($urandom);
		endcase
	endfunction

	task automatic feed(input logic [15:0] s);
		pending_samples.push_back(s);
	endtask

	// register write, mirror updated at the handshake
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_GROUP_LENGTH: cur_glen = data[10:0];
			REG_NOISE_FLOOR:  cur_floor = data;
			REG_FLOOR_GAIN:   cur_gain = data;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || in_valid || expected_levels.size() != 0)
			@(posedge clk);
	endtask

	// drained, then room for a group close still in flight
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one random setting followed by a few groups of random words
	task automatic random_phase(output int unsigned sent);
		int unsigned  glen_eff;
		int unsigned  count;
		logic [15:0]  gl_data;
		logic [15:0]  reg_val;
		sample_mix_t  mix;
		bit           pause;
		wait_idle();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8: gl_data = 16'd1;
			9:                         gl_data = 16'd0;
			10, 11, 12, 13, 14:        gl_data = 16'($urandom_range(2, 8));
			15, 16, 17:                gl_data = 16'($urandom_range(9, 64));
			18:                        gl_data = 16'(GROUP_LENGTH_RST);
			default:                   gl_data = 16'($urandom_range(65, 200));
		endcase
		// upper data bits lie outside the register
		if ($urandom_range(0, 1))
			gl_data[15:11] = 5'($urandom);
		write_reg(REG_GROUP_LENGTH, gl_data);
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 5))
				0:       reg_val = 16'h0000;
				1:       reg_val = 16'hFFFF;
				2:       reg_val = NOISE_FLOOR_RST;
				default: reg_val = 16'($urandom_range(0, 40000));
			endcase
			write_reg(REG_NOISE_FLOOR, reg_val);
		end
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 6))
				0:       reg_val = 16'h0000;
				1:       reg_val = 16'hFFFF;
				2:       reg_val = FLOOR_GAIN_RST;
				3:       reg_val = 16'h4000;
				default: reg_val = 16'($urandom);
			endcase
			write_reg(REG_FLOOR_GAIN, reg_val);
		end
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED, 16'($urandom));
		glen_eff = (gl_data[10:0] == 0) ? 1 : gl_data[10:0];
		if (glen_eff == 1)
			count = $urandom_range(4, 40);
		else if (glen_eff > 64)
			count = glen_eff + $urandom_range(0, 6);
		else
			count = $urandom_range(1, 6) * glen_eff + $urandom_range(0, 6) % glen_eff;
		mix = sample_mix_t'($urandom_range(0, MIX_ANY));
		pause = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < count; i++) begin
			// sender holds back until every level so far is in
			if (pause && i == count / 2)
				wait_drained();
			feed(pick_sample(mix));
		end
		sent = count;
	endtask

	// word acceptance and prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				absorb_sample(sample);
				samples_taken++;
			end
		end
	end

	// input driver, next word presented at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (feed_gap > 0) begin
				feed_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				sample <= pending_samples.pop_front();
				in_valid <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					feed_calm = !feed_calm;
				feed_gap = feed_calm ? 0 : $urandom_range(0, 18);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output ready with a random stall per word
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if ($urandom_range(0, 31) == 0)
					drain_calm = !drain_calm;
				drain_gap = drain_calm ? 0 : $urandom_range(0, 18);
			end
			if (drain_gap > 0) begin
				drain_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// level checker against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		level_word_t want;
		if (!arst_n) begin
			out_taken <= 1'b0;
		end else begin
			out_taken <= out_valid && out_ready;
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected level word: energy %0d slot %0d",
							energy_level, slot_index);
				end else begin
					want = expected_levels.pop_front();
					levels_checked++;
					if (want.energy !== energy_level || want.slot !== slot_index) begin
						fail_count++;
						if (fail_count <= 10)
							$display("level %0d: expected energy %0d slot %0d, got energy %0d slot %0d",
								levels_checked, want.energy, want.slot, energy_level, slot_index);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		int unsigned small_items;
		int unsigned sent;
		for (int i = 0; i < 256; i++)
			frac_log[i] = frac_log_of(i);
		small_items = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// one level per word: zero, extremes, alternating and byte patterns
		write_reg(REG_GROUP_LENGTH, 16'd1);
		feed(16'h0000);
		feed(16'h8000);
		feed(16'h7FFF);
		feed(16'hFFFF);
		feed(16'h0001);
		feed(16'h5555);
		feed(16'hAAAA);
		feed(16'h00FF);
		feed(16'hFF00);

		// zero group length acts as one
		wait_idle();
		write_reg(REG_GROUP_LENGTH, 16'd0);
		feed(16'd300);
		feed(16'hFED4);

		// group length lowered below the words already gathered
		wait_idle();
		write_reg(REG_GROUP_LENGTH, 16'd8);
		repeat (5) feed(16'($urandom));
		wait_idle();
		write_reg(REG_GROUP_LENGTH, 16'd3);
		feed(16'($urandom));

		// gain saturation, zero gain, floor above every level, write to the unused index
		wait_idle();
		write_reg(REG_GROUP_LENGTH, 16'd1);
		write_reg(REG_NOISE_FLOOR, 16'h0000);
		write_reg(REG_FLOOR_GAIN, 16'hFFFF);
		feed(16'h8000);
		wait_idle();
		write_reg(REG_FLOOR_GAIN, 16'h0000);
		feed(16'h3039);
		wait_idle();
		write_reg(REG_NOISE_FLOOR, 16'hFFFF);
		write_reg(REG_FLOOR_GAIN, 16'hFFFF);
		feed(16'h7FFF);
		wait_idle();
		write_reg(REG_UNUSED, 16'hA5A5);
		feed(16'h4000);

		// random settings, each followed by a few groups of words
		while (small_items < RANDOM_ITEMS) begin
			random_phase(sent);
			small_items += sent;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d words over %0d register writes",
			samples_taken, reg_writes);
		$display("%0d levels checked, ring slot wrapped %0d times, %0d failures",
			levels_checked, levels_checked / ENERGY_RING_DEPTH, fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
